/* hw/rtl/dsf_pkg.sv */
// shared types and constants for the damped spring force block
`default_nettype none
package dsf_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int DIST_W      = 2 * COORD_W + 2;
    localparam int LEN_W       = COORD_W + 1;
    localparam int PQ_W        = COORD_W + 2;
    localparam int FORCE_W     = 32;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPRING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DAMP   = 2'd2;

    localparam logic [CFG_W-1:0] CFG_SPRING_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] CFG_REST_RESET   = 31'd0;
    localparam logic [CFG_W-1:0] CFG_DAMP_RESET   = 31'd0;

    localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] d;
        logic [2:0][DIFF_W-1:0] v;
        logic                   zl;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] ks;
        logic [CFG_W-1:0] rest;
        logic [CFG_W-1:0] kd;
    } t_cfg;

endpackage
`default_nettype wire

/* hw/rtl/damped_spring_force_core.sv */
// throughput: one transaction per unstalled cycle, set by fully pipelined sqrt and dividers
// a four entry queue decouples the front end from the back pipeline, which stalls as a whole
// reset: synchronous active low, empties queue and pipeline, restores the three registers
// configuration port is always ready and takes effect at once
`default_nettype none
module damped_spring_force_core import dsf_pkg::*; #(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [31:0]    i_pos_a_x,
    input  wire logic signed [31:0]    i_pos_a_y,
    input  wire logic signed [31:0]    i_pos_a_z,
    input  wire logic signed [31:0]    i_pos_b_x,
    input  wire logic signed [31:0]    i_pos_b_y,
    input  wire logic signed [31:0]    i_pos_b_z,
    input  wire logic signed [31:0]    i_vel_a_x,
    input  wire logic signed [31:0]    i_vel_a_y,
    input  wire logic signed [31:0]    i_vel_a_z,
    input  wire logic signed [31:0]    i_vel_b_x,
    input  wire logic signed [31:0]    i_vel_b_y,
    input  wire logic signed [31:0]    i_vel_b_z,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [31:0]         o_force_x,
    output logic signed [31:0]         o_force_y,
    output logic signed [31:0]         o_force_z,
    output logic                       o_zero_length,
    output logic                       o_saturated,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg                    r_cfg;
    logic                    w_push;
    logic                    w_full;
    t_item                   w_front_item;
    logic                    w_q_valid;
    logic                    w_pop;
    t_item                   w_q_item;
    logic [2:0][FORCE_W-1:0] w_force;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ks   <= CFG_SPRING_RESET;
            r_cfg.rest <= CFG_REST_RESET;
            r_cfg.kd   <= CFG_DAMP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_SPRING: r_cfg.ks   <= i_cfg_data;
                CFG_IDX_REST:   r_cfg.rest <= i_cfg_data;
                CFG_IDX_DAMP:   r_cfg.kd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pa    ({i_pos_a_z, i_pos_a_y, i_pos_a_x}),
        .i_pb    ({i_pos_b_z, i_pos_b_y, i_pos_b_x}),
        .i_va    ({i_vel_a_z, i_vel_a_y, i_vel_a_x}),
        .i_vb    ({i_vel_b_z, i_vel_b_y, i_vel_b_x}),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_item  (w_front_item)
    );

    dsf_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    dsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_q_valid),
        .i_item        (w_q_item),
        .o_item_pop    (w_pop),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_force       (w_force),
        .o_zero_length (o_zero_length),
        .o_saturated   (o_saturated)
    );

    assign o_force_x = $signed(w_force[0]);
    assign o_force_y = $signed(w_force[1]);
    assign o_force_z = $signed(w_force[2]);

endmodule
`default_nettype wire

/* hw/rtl/dsf_front.sv */
// front end: takes a transaction, forms the offsets and flags coinciding particles
`default_nettype none
module dsf_front import dsf_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [2:0][COORD_W-1:0] i_pa,
    input  wire logic [2:0][COORD_W-1:0] i_pb,
    input  wire logic [2:0][COORD_W-1:0] i_va,
    input  wire logic [2:0][COORD_W-1:0] i_vb,
    output logic                         o_push,
    input  wire logic                    i_full,
    output t_item                        o_item
);

    logic  r_fv;
    t_item r_item;
    t_item n_item;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_item.d[i] = {i_pa[i][COORD_W-1], i_pa[i]} - {i_pb[i][COORD_W-1], i_pb[i]};
            n_item.v[i] = {i_va[i][COORD_W-1], i_va[i]} - {i_vb[i][COORD_W-1], i_vb[i]};
        end
        // zero offset is exactly the zero length case
        n_item.zl = (n_item.d == '0);
    end

    assign o_ready = !r_fv || !i_full;
    assign o_push  = r_fv && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/dsf_queue.sv */
// short register queue between the front end and the arithmetic pipeline
`default_nettype none
module dsf_queue import dsf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push_ok;
    logic               w_pop_ok;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= f_next(r_wr);
            end
            if (w_pop_ok) begin
                r_rd <= f_next(r_rd);
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_push_ok && w_pop_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (w_push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue pushed while full");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_ok && !w_pop_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

/* hw/rtl/dsf_sqrt.sv */
// pipelined floor square root, one result bit per stage, with sideband
`default_nettype none
module dsf_sqrt #(
    parameter int IN_W   = 66,
    parameter int OUT_W  = 33,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [OUT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int RW = IN_W + 2;

    logic [OUT_W-1:0]  r_root [OUT_W+1];
    logic [IN_W-1:0]   r_rem  [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W+1];
    logic [OUT_W:0]    r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[OUT_W-1:0], i_valid};
        end
        if (i_en) begin
            r_root[0] <= '0;
            r_rem[0]  <= i_rad;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < OUT_W; k++) begin : g_step
        localparam int B = OUT_W - 1 - k;
        logic [RW-1:0] trial;
        logic          ge;

        // remainder holds rad - root^2, trial is (2*root + 2^b) * 2^b
        assign trial = (RW'(r_root[k]) << (B + 1)) | (RW'(1) << (2 * B));
        assign ge    = (trial <= RW'(r_rem[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= ge ? (r_root[k] | (OUT_W'(1) << B)) : r_root[k];
                r_side[k+1] <= r_side[k];
            end
        end
        if (k < OUT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? IN_W'(RW'(r_rem[k]) - trial) : r_rem[k];
                end
            end
        end
    end

    assign o_valid = r_vld[OUT_W];
    assign o_root  = r_root[OUT_W];
    assign o_side  = r_side[OUT_W];

endmodule
`default_nettype wire

/* hw/rtl/dsf_div.sv */
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module dsf_div #(
    parameter int N_W    = 66,
    parameter int D_W    = 33,
    parameter int Q_W    = 34,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [N_W-1:0]    i_num,
    input  wire logic [D_W-1:0]    i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quo,
    output logic                   o_ovf,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int HI_W = N_W - Q_W;
    localparam int CW   = (HI_W > D_W) ? HI_W : D_W;

    logic [D_W-1:0]    r_rem  [Q_W];
    logic [D_W-1:0]    r_den  [Q_W];
    logic [Q_W-1:0]    r_low  [Q_W+1];
    logic              r_ovf  [Q_W+1];
    logic [SIDE_W-1:0] r_side [Q_W+1];
    logic [Q_W:0]      r_vld;
    logic [CW-1:0]     w_hi;

    assign w_hi = CW'(i_num[N_W-1:Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-1:0], i_valid};
        end
        if (i_en) begin
            // quotient does not fit when the upper part already reaches the divisor
            r_ovf[0]  <= (w_hi >= CW'(i_den));
            r_rem[0]  <= w_hi[D_W-1:0];
            r_low[0]  <= i_num[Q_W-1:0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [D_W:0] t;
        logic [D_W:0] sub;
        logic         ge;

        assign t   = {r_rem[k], r_low[k][Q_W-1]};
        assign sub = t - {1'b0, r_den[k]};
        assign ge  = (t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[k+1]  <= {r_low[k][Q_W-2:0], ge};
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? sub[D_W-1:0] : t[D_W-1:0];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_low[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule
`default_nettype wire

/* hw/rtl/dsf_back.sv */
// back end: length, projection, force terms, division and saturation
`default_nettype none
module dsf_back import dsf_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_item_valid,
    input  wire t_item                   i_item,
    output logic                         o_item_pop,
    input  wire t_cfg                    i_cfg,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [2:0][FORCE_W-1:0]      o_force,
    output logic                         o_zero_length,
    output logic                         o_saturated
);

    localparam int DD_W = 2 * COORD_W;
    localparam int VD_W = 2 * COORD_W + 1;
    localparam int P_W  = VD_W + 2;
    localparam int SP_W = CFG_W + LEN_W;
    localparam int DP_W = CFG_W + PQ_W;
    localparam int FRAC = 16;
    localparam int SM_W = SP_W - FRAC;
    localparam int DM_W = DP_W - FRAC;
    localparam int M_W  = DM_W + 2;
    localparam int MM_W = M_W - 1;
    localparam int ML_W = MM_W / 2;
    localparam int MH_W = MM_W - ML_W;
    localparam int PL_W = DIFF_W + ML_W;
    localparam int PH_W = DIFF_W + MH_W;
    localparam int PR_W = DIFF_W + MM_W;

    typedef struct packed {
        logic [DIST_W-1:0]      pmag;
        logic                   pneg;
        logic [2:0][DIFF_W-1:0] dmag;
        logic [2:0]             dneg;
        logic                   zl;
    } t_sq_side;

    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic                   pneg;
        logic [2:0][DIFF_W-1:0] dmag;
        logic [2:0]             dneg;
        logic                   zl;
    } t_pq_side;

    logic en;
    logic r_out_vld;

    assign en         = !r_out_vld || i_ready;
    assign o_item_pop = en;
    assign o_valid    = r_out_vld;

    // stage 1: squares, products and offset magnitudes
    logic signed [2*DIFF_W-1:0] w_sq [3];
    logic signed [2*DIFF_W-1:0] w_vd [3];
    logic [2:0][DIFF_W-1:0]     w_dm;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = $signed(i_item.d[i]) * $signed(i_item.d[i]);
            w_vd[i] = $signed(i_item.v[i]) * $signed(i_item.d[i]);
            w_dm[i] = i_item.d[i][DIFF_W-1] ? (~i_item.d[i] + DIFF_W'(1)) : i_item.d[i];
        end
    end

    logic                   r_v1;
    logic [DD_W-1:0]        r1_sq [3];
    logic signed [VD_W-1:0] r1_vd [3];
    logic [2:0][DIFF_W-1:0] r1_dm;
    logic [2:0]             r1_dn;
    logic                   r1_zl;

    // stage 2: sums
    logic                   r_v2;
    logic [DIST_W-1:0]      r2_q;
    logic signed [P_W-1:0]  r2_p;
    logic [2:0][DIFF_W-1:0] r2_dm;
    logic [2:0]             r2_dn;
    logic                   r2_zl;

    // stage 3: projection magnitude
    logic                   r_v3;
    logic [DIST_W-1:0]      r3_q;
    t_sq_side               r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_sq[i] <= w_sq[i][DD_W-1:0];
                r1_vd[i] <= w_vd[i][VD_W-1:0];
                r1_dn[i] <= i_item.d[i][DIFF_W-1];
            end
            r1_dm <= w_dm;
            r1_zl <= i_item.zl;

            r2_q  <= DIST_W'(r1_sq[0]) + DIST_W'(r1_sq[1]) + DIST_W'(r1_sq[2]);
            r2_p  <= P_W'(r1_vd[0]) + P_W'(r1_vd[1]) + P_W'(r1_vd[2]);
            r2_dm <= r1_dm;
            r2_dn <= r1_dn;
            r2_zl <= r1_zl;

            r3_q         <= r2_q;
            r3_side.pneg <= r2_p[P_W-1];
            r3_side.pmag <= r2_p[P_W-1] ? DIST_W'(-r2_p) : DIST_W'(r2_p);
            r3_side.dmag <= r2_dm;
            r3_side.dneg <= r2_dn;
            r3_side.zl   <= r2_zl;
        end
    end

    logic             w_sq_vld;
    logic [LEN_W-1:0] w_len;
    t_sq_side         w_sq_side;

    dsf_sqrt #(
        .IN_W   (DIST_W),
        .OUT_W  (LEN_W),
        .SIDE_W ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_rad   (r3_q),
        .i_side  (r3_side),
        .o_valid (w_sq_vld),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    t_pq_side        w_pq_in;
    logic            w_pq_vld;
    logic [PQ_W-1:0] w_pq;
    logic            w_pq_ovf;
    t_pq_side        w_pq_side;

    assign w_pq_in.len  = w_len;
    assign w_pq_in.pneg = w_sq_side.pneg;
    assign w_pq_in.dmag = w_sq_side.dmag;
    assign w_pq_in.dneg = w_sq_side.dneg;
    assign w_pq_in.zl   = w_sq_side.zl;

    dsf_div #(
        .N_W    (DIST_W),
        .D_W    (LEN_W),
        .Q_W    (PQ_W),
        .SIDE_W ($bits(t_pq_side))
    ) u_div_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_vld),
        .i_num   (w_sq_side.pmag),
        .i_den   (w_len),
        .i_side  (w_pq_in),
        .o_valid (w_pq_vld),
        .o_quo   (w_pq),
        .o_ovf   (w_pq_ovf),
        .o_side  (w_pq_side)
    );

    // stages 4 to 9: spring and damping terms, then offset times their sum
    logic                   r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic [LEN_W-1:0]       r4_diff;
    logic                   r4_sneg;
    logic [PQ_W-1:0]        r4_pq;
    t_pq_side               r4_side;
    logic [SP_W-1:0]        r5_sp;
    logic [DP_W-1:0]        r5_dp;
    logic                   r5_sneg;
    t_pq_side               r5_side;
    logic signed [M_W-1:0]  r6_m;
    t_pq_side               r6_side;
    logic [MM_W-1:0]        r7_mm;
    logic                   r7_mn;
    t_pq_side               r7_side;
    logic [PL_W-1:0]        r8_pl [3];
    logic [PH_W-1:0]        r8_ph [3];
    logic [2:0]             r8_pn;
    logic [LEN_W-1:0]       r8_len;
    logic                   r8_zl;
    logic [PR_W-1:0]        r9_pm [3];
    logic [2:0]             r9_pn;
    logic [LEN_W-1:0]       r9_len;
    logic                   r9_zl;

    logic signed [M_W-1:0]  w_ms;
    logic signed [M_W-1:0]  w_md;

    assign w_ms = r5_sneg ? -$signed(M_W'(r5_sp[SP_W-1:FRAC]))
                          :  $signed(M_W'(r5_sp[SP_W-1:FRAC]));
    assign w_md = r5_side.pneg ? -$signed(M_W'(r5_dp[DP_W-1:FRAC]))
                               :  $signed(M_W'(r5_dp[DP_W-1:FRAC]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v4 <= w_pq_vld;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
        if (en) begin
            r4_sneg <= (w_pq_side.len < LEN_W'(i_cfg.rest));
            r4_diff <= (w_pq_side.len < LEN_W'(i_cfg.rest))
                     ? LEN_W'(i_cfg.rest) - w_pq_side.len
                     : w_pq_side.len - LEN_W'(i_cfg.rest);
            r4_pq   <= w_pq;
            r4_side <= w_pq_side;

            r5_sp   <= SP_W'(i_cfg.ks) * SP_W'(r4_diff);
            r5_dp   <= DP_W'(i_cfg.kd) * DP_W'(r4_pq);
            r5_sneg <= r4_sneg;
            r5_side <= r4_side;

            r6_m    <= w_ms + w_md;
            r6_side <= r5_side;

            r7_mn   <= r6_m[M_W-1];
            r7_mm   <= r6_m[M_W-1] ? MM_W'(-r6_m) : MM_W'(r6_m);
            r7_side <= r6_side;

            for (int i = 0; i < 3; i++) begin
                r8_pl[i] <= PL_W'(r7_side.dmag[i]) * PL_W'(r7_mm[ML_W-1:0]);
                r8_ph[i] <= PH_W'(r7_side.dmag[i]) * PH_W'(r7_mm[MM_W-1:ML_W]);
                r8_pn[i] <= r7_side.dneg[i] ^ r7_mn;
                r9_pm[i] <= (PR_W'(r8_ph[i]) << ML_W) + PR_W'(r8_pl[i]);
            end
            r8_len <= r7_side.len;
            r8_zl  <= r7_side.zl;
            r9_pn  <= r8_pn;
            r9_len <= r8_len;
            r9_zl  <= r8_zl;
        end
    end

    logic [2:0]         w_fv;
    logic [FORCE_W-1:0] w_fq [3];
    logic [2:0]         w_fo;
    logic [1:0]         w_fs [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        dsf_div #(
            .N_W    (PR_W),
            .D_W    (LEN_W),
            .Q_W    (FORCE_W),
            .SIDE_W (2)
        ) u_div_force (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_v9),
            .i_num   (r9_pm[i]),
            .i_den   (r9_len),
            .i_side  ({r9_pn[i], r9_zl}),
            .o_valid (w_fv[i]),
            .o_quo   (w_fq[i]),
            .o_ovf   (w_fo[i]),
            .o_side  (w_fs[i])
        );
    end

    logic [2:0][FORCE_W-1:0] w_force;
    logic [2:0]              w_sat;

    // negative product gives a positive force on A and the other way round
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_fs[i][1]) begin
                w_sat[i]   = w_fo[i] || w_fq[i][FORCE_W-1];
                w_force[i] = w_sat[i] ? FORCE_MAX : w_fq[i];
            end else begin
                w_sat[i]   = w_fo[i] || (w_fq[i][FORCE_W-1] && (w_fq[i][FORCE_W-2:0] != '0));
                w_force[i] = w_sat[i] ? FORCE_MIN : (~w_fq[i] + FORCE_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_fv[0];
        end
        if (en) begin
            if (w_fs[0][0]) begin
                o_force       <= '0;
                o_zero_length <= 1'b1;
                o_saturated   <= 1'b0;
            end else begin
                o_force       <= w_force;
                o_zero_length <= 1'b0;
                o_saturated   <= |w_sat;
            end
        end
    end

`ifndef SYNTHESIS
    a_proj_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pq_vld && !w_pq_side.zl) |-> !w_pq_ovf)
        else $error("projection quotient out of range");
    a_lanes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fv[0] == w_fv[1]) && (w_fv[1] == w_fv[2]))
        else $error("force lanes out of step");
    a_lanes_zl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fv[0] |-> ((w_fs[1][0] == w_fs[0][0]) && (w_fs[2][0] == w_fs[0][0])))
        else $error("force lanes disagree on zero length");
`endif

endmodule
`default_nettype wire

/* bench/tb_damped_spring_force_core.sv */
// self-checking testbench for the damped spring force core
`default_nettype none
module tb_damped_spring_force_core;
    import dsf_pkg::*;

    localparam int LATENCY   = 113;
    localparam int MAX_CYCLE = 2000000;
    localparam int N_RANDOM  = 1080;

    typedef struct {
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        logic signed [31:0] va [3];
        logic signed [31:0] vb [3];
    } t_pair;

    typedef struct {
        logic signed [31:0] f [3];
        logic               zl;
        logic               sat;
    } t_force;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [31:0]       pin [12];
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [31:0]       o_force_x, o_force_y, o_force_z;
    logic                     o_zero_length, o_saturated;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_IDX_SPRING;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    logic [CFG_W-1:0] ks_model, rest_model, kd_model;
    t_force           force_queue [$];
    int               n_errors = 0;
    int               n_checked = 0;
    int               n_sent = 0;
    int               n_zero = 0;
    int               n_sat = 0;
    int               cycle = 0;

    initial for (int i = 0; i < 12; i++) pin[i] = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    damped_spring_force_core dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_pos_a_x(pin[0]), .i_pos_a_y(pin[1]), .i_pos_a_z(pin[2]),
        .i_pos_b_x(pin[3]), .i_pos_b_y(pin[4]), .i_pos_b_z(pin[5]),
        .i_vel_a_x(pin[6]), .i_vel_a_y(pin[7]), .i_vel_a_z(pin[8]),
        .i_vel_b_x(pin[9]), .i_vel_b_y(pin[10]), .i_vel_b_z(pin[11]),
        .o_valid, .i_ready, .o_force_x, .o_force_y, .o_force_z,
        .o_zero_length, .o_saturated,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    // floor square root of a nonnegative value below 2^66
    function automatic logic [32:0] root_floor(input logic [67:0] q);
        logic [32:0] r;
        logic [33:0] t;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            t = {1'b0, r} | (34'd1 << b);
            if (68'(t) * 68'(t) <= q) r = t[32:0];
        end
        return r;
    endfunction

    function automatic t_force spring_force(input t_pair p);
        t_force               res;
        logic signed [33:0]   d [3];
        logic signed [33:0]   v [3];
        logic signed [69:0]   q, pd;
        logic [32:0]          len;
        logic [69:0]          pmag;
        logic [69:0]          proj;
        logic signed [35:0]   diff;
        logic [69:0]          spr_mag, dmp_mag;
        logic signed [72:0]   m;
        logic signed [127:0]  prod;
        logic [127:0]         pm, fm;
        logic                 pneg;
        res.sat = 1'b0;
        res.zl = 1'b0;
        q = '0;
        pd = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 34'(p.pa[i]) - 34'(p.pb[i]);
            v[i] = 34'(p.va[i]) - 34'(p.vb[i]);
            q += 70'(d[i]) * 70'(d[i]);
            pd += 70'(v[i]) * 70'(d[i]);
        end
        len = root_floor(q[67:0]);
        if (len == 0) begin
            for (int i = 0; i < 3; i++) res.f[i] = '0;
            res.zl = 1'b1;
            return res;
        end
        pneg = pd < 0;
        pmag = pneg ? -pd : pd;
        proj = pmag / len;
        diff = 36'($signed({1'b0, len})) - 36'($signed({1'b0, rest_model}));
        spr_mag = (70'(ks_model) * 70'(diff < 0 ? -diff : diff)) >> 16;
        dmp_mag = 70'((128'(kd_model) * 128'(proj)) >> 16);
        m = (diff < 0 ? -73'(spr_mag) : 73'(spr_mag))
            + (pneg ? -73'(dmp_mag) : 73'(dmp_mag));
        for (int i = 0; i < 3; i++) begin
            prod = 128'(d[i]) * 128'(m);
            pm = prod < 0 ? -prod : prod;
            fm = pm / len;
            if (prod < 0) begin
                if (fm > 128'h7FFF_FFFF) begin
                    fm = 128'h7FFF_FFFF;
                    res.sat = 1'b1;
                end
                res.f[i] = fm[31:0];
            end else begin
                if (fm > 128'h8000_0000) begin
                    fm = 128'h8000_0000;
                    res.sat = 1'b1;
                end
                res.f[i] = -fm[31:0];
            end
        end
        return res;
    endfunction

    task automatic idle_gap(input int pct);
        int n;
        if ($urandom_range(99) < pct) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // leaves the write strobe high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IDX_SPRING: ks_model = val;
            CFG_IDX_REST:   rest_model = val;
            CFG_IDX_DAMP:   kd_model = val;
            default: ;
        endcase
    endtask

    // sends one pair; when a known force is given it is checked directly
    task automatic send_pair(input t_pair p, input bit known, input t_force want);
        t_force exp_f;
        exp_f = known ? want : spring_force(p);
        for (int i = 0; i < 3; i++) begin
            pin[i] <= p.pa[i];
            pin[3+i] <= p.pb[i];
            pin[6+i] <= p.va[i];
            pin[9+i] <= p.vb[i];
        end
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        force_queue.push_back(exp_f);
        n_sent++;
        if (exp_f.zl) n_zero++;
        if (exp_f.sat) n_sat++;
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        while (force_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed(32'($urandom_range(2 * 65536))) - 65536 * 1;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int    mode;
        mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(9) == 0 ? 3 : $urandom_range(2, 1));
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = rand_coord(mode);
            p.pb[i] = ($urandom_range(19) == 0) ? p.pa[i] : rand_coord(mode);
            p.va[i] = rand_coord($urandom_range(9) < 2 ? 0 : 2);
            p.vb[i] = rand_coord($urandom_range(9) < 2 ? 0 : 2);
        end
        return p;
    endfunction

    function automatic t_pair make_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                                        input logic signed [31:0] va,
                                        input logic signed [31:0] vb);
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = a;
            p.pb[i] = b;
            p.va[i] = va;
            p.vb[i] = vb;
        end
        return p;
    endfunction

    // directed stimulus rows: positions and velocities replicated on each axis
    typedef struct {
        logic signed [31:0] a, b, va, vb;
        bit                 known;
        logic signed [31:0] fx;
        logic               zl, sat;
    } t_row;

    t_row directed_rows [] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'sd0, 1'b1, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'sd0, 1'b1, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd1, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd1, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd0, -32'sd65536, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd123456, 32'sd123456, 32'sd99, 32'sd7, 1'b1, 32'sd0, 1'b1, 1'b0}
    };

    function automatic t_force row_force(input t_row r);
        t_force f;
        for (int i = 0; i < 3; i++) f.f[i] = r.fx;
        f.zl = r.zl;
        f.sat = r.sat;
        return f;
    endfunction

    task automatic run_directed();
        foreach (directed_rows[k]) begin
            send_pair(make_pair(directed_rows[k].a, directed_rows[k].b, directed_rows[k].va,
                                directed_rows[k].vb), directed_rows[k].known,
                      row_force(directed_rows[k]));
            idle_gap(30);
        end
    endtask

    task automatic run_random(input int count);
        t_force unused;
        for (int k = 0; k < count; k++) begin
            send_pair(rand_pair(), 1'b0, unused);
            if ($urandom_range(3) != 0) idle_gap(35);
            if (k == count / 2) begin
                // hold off until the pipeline has handed back every result
                i_valid <= 1'b0;
                while (force_queue.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_force exp_f;
        cycle <= cycle + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (force_queue.size() == 0) begin
                $error("result transaction with no expectation pending");
                n_errors++;
            end else begin
                exp_f = force_queue.pop_front();
                n_checked++;
                if (o_force_x !== exp_f.f[0]) begin
                    $error("force_x expected %0d actual %0d", exp_f.f[0], o_force_x);
                    n_errors++;
                end
                if (o_force_y !== exp_f.f[1]) begin
                    $error("force_y expected %0d actual %0d", exp_f.f[1], o_force_y);
                    n_errors++;
                end
                if (o_force_z !== exp_f.f[2]) begin
                    $error("force_z expected %0d actual %0d", exp_f.f[2], o_force_z);
                    n_errors++;
                end
                if (o_zero_length !== exp_f.zl) begin
                    $error("zero_length expected %0d actual %0d", exp_f.zl, o_zero_length);
                    n_errors++;
                end
                if (o_saturated !== exp_f.sat) begin
                    $error("saturated expected %0d actual %0d", exp_f.sat, o_saturated);
                    n_errors++;
                end
            end
        end
        if (!i_rst_n) i_ready <= 1'b0;
        else if ((cycle / 3000) % 4 == 1) i_ready <= 1'b1;
        else if ($urandom_range(49) == 0) i_ready <= 1'b0;
        else if ($urandom_range(9) < 7) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(3) == 0);
    end

    always @(posedge i_clk) begin
        if (cycle >= MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] ks_set [4];
        logic [CFG_W-1:0] rest_set [4];
        logic [CFG_W-1:0] kd_set [4];
        ks_model = CFG_SPRING_RESET;
        rest_model = CFG_REST_RESET;
        kd_model = CFG_DAMP_RESET;
        ks_set = '{31'h7FFF_FFFF, 31'd0, 31'd1000, 31'd3 << 16};
        rest_set = '{31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd200000};
        kd_set = '{31'h7FFF_FFFF, 31'd32768, 31'd0, 31'd5 << 16};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(N_RANDOM / 5);
        for (int s = 0; s < 4; s++) begin
            drain_all();
            write_reg(CFG_IDX_SPRING, ks_set[s]);
            write_reg(CFG_IDX_REST, rest_set[s]);
            write_reg(CFG_IDX_DAMP, kd_set[s]);
            i_cfg_valid <= 1'b0;
            if (s == 0) run_directed();
            run_random(N_RANDOM / 5);
        end
        drain_all();
        $display("checked %0d of %0d force results over 5 register settings", n_checked, n_sent);
        $display("coinciding pairs %0d, clipped results %0d", n_zero, n_sat);
        if (n_errors == 0 && force_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* damped_spring_force_core.f */
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_front.sv
hw/rtl/dsf_queue.sv
hw/rtl/dsf_sqrt.sv
hw/rtl/dsf_div.sv
hw/rtl/dsf_back.sv
hw/rtl/damped_spring_force_core.sv
bench/tb_damped_spring_force_core.sv
